/* src/dctb_pkg.sv */
`timescale 1ns / 1ps

package dctb_pkg;

  // Number of byte entries in the transmit store.
  localparam int unsigned BUF_DEPTH = 256;
  localparam int unsigned ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  // The fill count and the send pointer must be able to hold BUF_DEPTH itself.
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FILL_W    = 9;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEND   = 2'd2,
    OP_DONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_WRONG   = 3'd2,
    ST_BUSY    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CT_NONE = 2'd0,
    CT_CMD  = 2'd1,
    CT_DATA = 2'd2
  } ctype_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic              tx_valid;
    logic              cs_level;
    logic              dc_level;
    logic              busy;
    logic [FILL_W-1:0] fill;
  } res_t;

endpackage

/* src/dctb_ram.sv */
`timescale 1ns / 1ps

module dctb_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dctb_ctrl.sv */
`timescale 1ns / 1ps

module dctb_ctrl import dctb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        opcode_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              is_data_i,
  output mem_req_t          mem_req_o,
  output res_t              res_o
);

  logic [CNT_W-1:0] fill_q, fill_d;
  ctype_e           ctype_q, ctype_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic             xmit_q, xmit_d;
  logic             cs_q, cs_d;
  logic             dc_q, dc_d;
  ctype_e           want;
  status_e          status;
  logic             txv;
  op_e              op;

  assign op   = op_e'(opcode_i);
  assign want = is_data_i ? CT_DATA : CT_CMD;

  always_comb begin
    fill_d    = fill_q;
    ctype_d   = ctype_q;
    idx_d     = idx_q;
    len_d     = len_q;
    xmit_d    = xmit_q;
    cs_d      = cs_q;
    dc_d      = dc_q;
    status    = ST_OK;
    txv       = 1'b0;
    mem_req_o = '0;
    mem_req_o.wdata = byte_value_i;

    if (op == OP_DONE) begin
      if (xmit_q) begin
        if (idx_q < len_q && idx_q < CNT_W'(BUF_DEPTH)) begin
          txv             = 1'b1;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[ADDR_W-1:0];
          idx_d           = idx_q + CNT_W'(1);
        end else begin
          cs_d   = 1'b1;
          xmit_d = 1'b0;
        end
      end
    end else if (xmit_q) begin
      status = ST_BUSY;
    end else begin
      case (op)
        OP_CLEAR: begin
          fill_d  = '0;
          ctype_d = CT_NONE;
        end
        OP_APPEND: begin
          if (fill_q >= CNT_W'(BUF_DEPTH)) begin
            status = ST_FULL;
          end else if (ctype_q != CT_NONE && ctype_q != want) begin
            status = ST_WRONG;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = fill_q[ADDR_W-1:0];
            fill_d          = fill_q + CNT_W'(1);
            ctype_d         = want;
          end
        end
        OP_SEND: begin
          if (ctype_q == CT_CMD || ctype_q == CT_DATA) begin
            dc_d            = (ctype_q == CT_DATA);
            cs_d            = 1'b0;
            xmit_d          = 1'b1;
            len_d           = fill_q;
            idx_d           = CNT_W'(1);
            txv             = 1'b1;
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = '0;
          end else begin
            status = ST_UNKNOWN;
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end

    // Nothing reaches the store unless the beat is really taken.
    mem_req_o.we = mem_req_o.we & accept_i;
    mem_req_o.re = mem_req_o.re & accept_i;
  end

  always_comb begin
    res_o.status   = status;
    res_o.tx_valid = txv;
    res_o.cs_level = cs_d;
    res_o.dc_level = dc_d;
    res_o.busy     = xmit_d;
    res_o.fill     = FILL_W'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ctype_q <= CT_NONE;
      idx_q   <= '0;
      len_q   <= '0;
      xmit_q  <= 1'b0;
      cs_q    <= 1'b1;
      dc_q    <= 1'b0;
    end else if (accept_i) begin
      fill_q  <= fill_d;
      ctype_q <= ctype_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      xmit_q  <= xmit_d;
      cs_q    <= cs_d;
      dc_q    <= dc_d;
    end
  end

endmodule

/* src/display_cmd_data_tx_buffer_core.sv */
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    opcode_i, byte_value_i, is_data_i
// output    out_valid_o / out_stall_i  status_o, tx_valid_o, tx_byte_o, cs_level_o,
//                                      dc_level_o, busy_res_o, fill_level_o
//
// One input beat is taken per cycle while the result side keeps moving; each beat
// gives exactly one result beat, which passes through the read stage, where the
// byte store is read, and then through the output register.
// Reset clears the fill count, the content type, the transfer state and the pipeline;
// chip select comes out of reset high. The byte store itself is not cleared.
// When the result side stalls, one result waits in the output register and one in
// the read stage; only then is the input stalled.

module display_cmd_data_tx_buffer_core import dctb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              is_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic              tx_valid_o,
  output logic [BYTE_W-1:0] tx_byte_o,
  output logic              cs_level_o,
  output logic              dc_level_o,
  output logic              busy_res_o,
  output logic [FILL_W-1:0] fill_level_o
);

  mem_req_t          mem_req;
  res_t              res;
  logic [BYTE_W-1:0] rdata;
  logic              accept;
  logic              out_free;
  logic              s1_move;

  // Read stage: the result of the beat while the store read is under way.
  logic              s1_valid_q, s1_valid_d;
  res_t              s1_res_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;
  logic [BYTE_W-1:0] out_byte_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  dctb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (opcode_i),
    .byte_value_i (byte_value_i),
    .is_data_i    (is_data_i),
    .mem_req_o    (mem_req),
    .res_o        (res)
  );

  // The store is read only on an accepted beat, so its read data holds while the
  // read stage waits for the output register.
  dctb_ram #(
    .DEPTH  (BUF_DEPTH),
    .WIDTH  (BYTE_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_valid_d = accept || (s1_valid_q && !s1_move);
    out_valid_d = s1_move || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      out_res_q  <= s1_res_q;
      // A beat that hands no byte to the shifter reports a zero byte.
      out_byte_q <= s1_res_q.tx_valid ? rdata : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_res_q.status;
  assign tx_valid_o   = out_res_q.tx_valid;
  assign tx_byte_o    = out_byte_q;
  assign cs_level_o   = out_res_q.cs_level;
  assign dc_level_o   = out_res_q.dc_level;
  assign busy_res_o   = out_res_q.busy;
  assign fill_level_o = out_res_q.fill;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dctb_pkg::*;

  // One result beat as it is seen on the output port. The packed form lets a
  // whole beat be compared in one go, X and Z included.
  typedef struct packed {
    logic [2:0]        status;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              cs_level;
    logic              dc_level;
    logic              busy;
    logic [FILL_W-1:0] fill;
  } reply_t;

  // Keeps its own copy of the transmit buffer. Every accepted input beat is
  // played through it, and the reply that the block ought to give is queued.
  // Replies leave the block in order, so each one is compared with the oldest
  // reply still waiting.
  class dctb_tracker;
    logic [BYTE_W-1:0] store [BUF_DEPTH];
    int unsigned       fill_cnt;
    int unsigned       send_idx;
    int unsigned       send_len;
    ctype_e            ctype;
    bit                sending;
    bit                cs_line;
    bit                dc_line;
    reply_t            pending_replies [$];
    int unsigned       errors;

    function new();
      fill_cnt = 0;
      send_idx = 0;
      send_len = 0;
      ctype    = CT_NONE;
      sending  = 1'b0;
      cs_line  = 1'b1;
      dc_line  = 1'b0;
      errors   = 0;
    endfunction

    function void take_command(op_e op, logic [BYTE_W-1:0] val, logic is_data);
      reply_t r;
      ctype_e want;
      want       = is_data ? CT_DATA : CT_CMD;
      r          = '0;
      r.status   = ST_OK;
      if (op == OP_DONE) begin
        // A byte-done with no transfer running changes nothing at all.
        if (sending) begin
          if (send_idx < send_len && send_idx < BUF_DEPTH) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = store[send_idx];
            send_idx++;
          end else begin
            cs_line = 1'b1;
            sending = 1'b0;
          end
        end
      end else if (sending) begin
        r.status = ST_BUSY;
      end else begin
        case (op)
          OP_CLEAR: begin
            fill_cnt = 0;
            ctype    = CT_NONE;
          end
          OP_APPEND: begin
            // A full store is reported ahead of a type clash.
            if (fill_cnt >= BUF_DEPTH) begin
              r.status = ST_FULL;
            end else if (ctype != CT_NONE && ctype != want) begin
              r.status = ST_WRONG;
            end else begin
              store[fill_cnt] = val;
              fill_cnt++;
              ctype = want;
            end
          end
          default: begin
            if (ctype == CT_NONE) begin
              r.status = ST_UNKNOWN;
            end else begin
              dc_line    = (ctype == CT_DATA);
              cs_line    = 1'b0;
              sending    = 1'b1;
              send_len   = fill_cnt;
              send_idx   = 1;
              r.tx_valid = 1'b1;
              r.tx_byte  = store[0];
            end
          end
        endcase
      end
      r.cs_level = cs_line;
      r.dc_level = dc_line;
      r.busy     = sending;
      r.fill     = fill_cnt[FILL_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result beat with nothing expected: status %0d tx %b/%h",
                   $realtime, got.status, got.tx_valid, got.tx_byte,
                   " cs %b dc %b busy %b fill %0d",
                   got.cs_level, got.dc_level, got.busy, got.fill);
        end
        return;
      end
      want = pending_replies.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch, expected status %0d tx %b/%h cs %b dc %b busy %b fill %0d",
                   $realtime, want.status, want.tx_valid, want.tx_byte, want.cs_level,
                   want.dc_level, want.busy, want.fill);
          $display("%0t:            actual status %0d tx %b/%h cs %b dc %b busy %b fill %0d",
                   $realtime, got.status, got.tx_valid, got.tx_byte, got.cs_level,
                   got.dc_level, got.busy, got.fill);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [1:0]        opcode_i     = OP_CLEAR;
  logic [BYTE_W-1:0] byte_value_i = '0;
  logic              is_data_i    = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [2:0]        status_o;
  logic              tx_valid_o;
  logic [BYTE_W-1:0] tx_byte_o;
  logic              cs_level_o;
  logic              dc_level_o;
  logic              busy_res_o;
  logic [FILL_W-1:0] fill_level_o;

  dctb_tracker tracker = new();

  // Whether each side inserts idle cycles at present. Both are switched now
  // and then, so that long runs at full rate alternate with ragged ones.
  bit          send_gaps  = 1'b1;
  bit          recv_gaps  = 1'b1;
  int unsigned beats_sent = 0;

  display_cmd_data_tx_buffer_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .byte_value_i (byte_value_i),
    .is_data_i    (is_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .cs_level_o   (cs_level_o),
    .dc_level_o   (dc_level_o),
    .busy_res_o   (busy_res_o),
    .fill_level_o (fill_level_o)
  );

  always #2 clk_i = ~clk_i;

  // Random byte and random single bit at the widths of the input ports.
  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offers one input beat and returns at the edge where it is taken. All
  // signals are changed with nonblocking assignments at a rising edge, and
  // the stall is looked at as it stood just before that edge. Valid stays
  // high from one beat to the next when no gap is drawn, so it is assigned
  // only once in that step.
  task automatic put_beat(op_e op, logic [BYTE_W-1:0] val, logic is_data);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    byte_value_i <= val;
    is_data_i    <= is_data;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.take_command(op, val, is_data);
    beats_sent++;
  endtask

  // A beat of any kind with random content, used as noise.
  task automatic put_noise();
    put_beat(op_e'($urandom_range(0, 3)), rnd_byte(), rnd_bit());
  endtask

  // A complete transfer: clear, fill with len bytes of one type, send, then
  // byte-done events until chip select is raised again. When noisy, stray
  // beats are mixed in: appends of the other type while filling, and
  // commands that must be turned away as busy while the transfer runs.
  // A store filled to the brim is offered one more byte of each type, both
  // of which must come back as full rather than as a type clash.
  task automatic run_transfer(int unsigned len, logic is_data, bit noisy);
    int unsigned i;
    put_beat(OP_CLEAR, rnd_byte(), rnd_bit());
    for (i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        put_beat(OP_APPEND, rnd_byte(), ~is_data);
      end
      put_beat(OP_APPEND, rnd_byte(), is_data);
    end
    if (len >= BUF_DEPTH) begin
      put_beat(OP_APPEND, rnd_byte(), is_data);
      put_beat(OP_APPEND, rnd_byte(), ~is_data);
    end
    put_beat(OP_SEND, rnd_byte(), rnd_bit());
    for (i = 0; i <= len; i++) begin
      if (noisy && $urandom_range(0, 5) == 0) begin
        put_beat(op_e'($urandom_range(0, 2)), rnd_byte(), rnd_bit());
      end
      put_beat(OP_DONE, rnd_byte(), rnd_bit());
    end
    if ($urandom_range(0, 3) == 0) begin
      put_beat(OP_DONE, rnd_byte(), rnd_bit());
    end
  endtask

  // Result side: a random stall is drawn for each result, then the stall is
  // dropped and the next result is taken at the first edge where valid is
  // high. Outputs are read as they stood just before that edge.
  initial begin : result_side
    int unsigned hold;
    reply_t      got;
    @(posedge clk_i);
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        recv_gaps = ~recv_gaps;
      end
      hold = recv_gaps ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.status   = status_o;
      got.tx_valid = tx_valid_o;
      got.tx_byte  = tx_byte_o;
      got.cs_level = cs_level_o;
      got.dc_level = dc_level_o;
      got.busy     = busy_res_o;
      got.fill     = fill_level_o;
      tracker.check_reply(got);
    end
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: a stray byte-done and a send with no type straight
    // out of reset, the extreme byte values, a type clash, every command
    // refused as busy mid-transfer, and a second transfer of data bytes.
    put_beat(OP_DONE,   8'h00, 1'b0);
    put_beat(OP_SEND,   8'hFF, 1'b1);
    put_beat(OP_APPEND, 8'h00, 1'b0);
    put_beat(OP_APPEND, 8'hFF, 1'b0);
    put_beat(OP_APPEND, 8'h55, 1'b1);
    put_beat(OP_SEND,   8'h00, 1'b0);
    put_beat(OP_APPEND, 8'hAA, 1'b0);
    put_beat(OP_CLEAR,  8'h00, 1'b0);
    put_beat(OP_SEND,   8'h00, 1'b1);
    put_beat(OP_DONE,   8'hFF, 1'b1);
    put_beat(OP_DONE,   8'h00, 1'b0);
    put_beat(OP_DONE,   8'h00, 1'b0);
    put_beat(OP_CLEAR,  8'hFF, 1'b1);
    put_beat(OP_SEND,   8'h00, 1'b0);
    put_beat(OP_APPEND, 8'hA5, 1'b1);
    put_beat(OP_APPEND, 8'h5A, 1'b1);
    put_beat(OP_APPEND, 8'h3C, 1'b0);
    put_beat(OP_SEND,   8'h00, 1'b0);
    put_beat(OP_DONE,   8'h00, 1'b0);
    put_beat(OP_DONE,   8'h00, 1'b0);
    put_beat(OP_DONE,   8'h00, 1'b0);

    // The store is filled to the brim once with command bytes, and later a noisy
    // full-length transfer of data bytes is run. The rest is mostly short transfers
    // with random bytes, some noisy, a few longer ones, and bursts of random beats.
    run_transfer(BUF_DEPTH, 1'b0, 1'b0);
    while (beats_sent < 1700) begin
      if (beats_sent > 900 && beats_sent < 1000) begin
        run_transfer(BUF_DEPTH, 1'b1, 1'b1);
      end
      send_gaps = ($urandom_range(0, 3) != 0);
      pick      = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        run_transfer(len, rnd_bit(), rnd_bit());
      end else begin
        repeat ($urandom_range(1, 6)) put_noise();
      end
    end

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    // Give a stray extra result the chance to show up before judging.
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("PASS display_cmd_data_tx_buffer_core");
    end else begin
      $display("FAIL display_cmd_data_tx_buffer_core");
    end
    $finish;
  end

  // Far beyond the slowest correct run, which stays well under a millisecond.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL display_cmd_data_tx_buffer_core");
    $finish;
  end

endmodule

/* display_cmd_data_tx_buffer_core.f */
src/dctb_pkg.sv
src/dctb_ram.sv
src/dctb_ctrl.sv
src/display_cmd_data_tx_buffer_core.sv
sim/tb.sv
